// File: hw/rtl/jeu_pkg.sv
// ----------------------------------------------------------------------------
// jeu_pkg
// Shared types, character codes and the UTF-8 encoder of the JSON string
// unescape block.
// ----------------------------------------------------------------------------
package jeu_pkg;

  // Depth of the group queue between the escape decoder and the collapser.
  localparam int unsigned QDEPTH = 4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // The tail "amp;" that follows an ampersand.
  localparam logic [7:0] AMP_TAIL [4] = '{8'h61, 8'h6D, 8'h70, 8'h3B};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       no_byte;
    logic       out_last;
  } out_t;

  // Bytes produced by the escape decoder for one input item.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } grp_t;

  function automatic grp_t utf8_enc(input logic [15:0] v);
    grp_t g;
    g = '0;
    if (v == 16'h0000) begin
      g.cnt = 2'd0;
    end else if (v < 16'h0080) begin
      g.bytes[0] = v[7:0];
      g.cnt      = 2'd1;
    end else if (v < 16'h0800) begin
      g.bytes[0] = 8'hC0 | {3'b000, v[10:6]};
      g.bytes[1] = 8'h80 | {2'b00, v[5:0]};
      g.cnt      = 2'd2;
    end else begin
      g.bytes[0] = 8'hE0 | {4'b0000, v[15:12]};
      g.bytes[1] = 8'h80 | {2'b00, v[11:6]};
      g.bytes[2] = 8'h80 | {2'b00, v[5:0]};
      g.cnt      = 2'd3;
    end
    return g;
  endfunction

endpackage

// File: hw/rtl/jeu_front.sv
// ----------------------------------------------------------------------------
// jeu_front
// Escape decoder: takes one byte per cycle while the queue has room and turns
// backslash escapes into a group of up to three bytes for the queue.
// ----------------------------------------------------------------------------
module jeu_front import jeu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic q_full,
  output logic push,
  output grp_t push_data
);

  typedef enum logic [1:0] {M_TEXT, M_ESC, M_HEX} mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_value, code_value_next;
  logic        hex_stopped, hex_stopped_next;
  grp_t        grp;
  logic        take;
  logic        dig_ok;
  logic [3:0]  dig;

  always_comb begin
    dig_ok = 1'b1;
    dig    = 4'd0;
    if (in_data.in_byte >= 8'h30 && in_data.in_byte <= 8'h39) begin
      dig = in_data.in_byte[3:0];
    end else if ((in_data.in_byte >= 8'h61 && in_data.in_byte <= 8'h66) ||
                 (in_data.in_byte >= 8'h41 && in_data.in_byte <= 8'h46)) begin
      dig = in_data.in_byte[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    grp              = '0;
    mode_next        = mode;
    hex_count_next   = hex_count;
    code_value_next  = code_value;
    hex_stopped_next = hex_stopped;
    unique case (mode)
      M_ESC: begin
        mode_next = M_TEXT;
        if (in_data.in_byte == CH_SLASH) begin
          grp.bytes[0] = CH_SLASH;
          grp.cnt      = 2'd1;
        end else if (in_data.in_byte == CH_LOW_R) begin
          grp.bytes[0] = CH_CR;
          grp.cnt      = 2'd1;
        end else if (in_data.in_byte == CH_LOW_N) begin
          grp.bytes[0] = CH_LF;
          grp.cnt      = 2'd1;
        end else if (in_data.in_byte == CH_LOW_U) begin
          mode_next        = M_HEX;
          hex_count_next   = 2'd0;
          code_value_next  = 16'h0000;
          hex_stopped_next = 1'b0;
        end else begin
          grp.bytes[0] = CH_BSLASH;
          grp.bytes[1] = in_data.in_byte;
          grp.cnt      = 2'd2;
        end
      end
      M_HEX: begin
        if (!hex_stopped && dig_ok) begin
          code_value_next = {code_value[11:0], dig};
        end else begin
          hex_stopped_next = 1'b1;
        end
        hex_count_next = hex_count + 2'd1;
        if (hex_count == 2'd3) begin
          grp              = utf8_enc(code_value_next);
          mode_next        = M_TEXT;
          hex_count_next   = 2'd0;
          code_value_next  = 16'h0000;
          hex_stopped_next = 1'b0;
        end
      end
      default: begin
        if (in_data.in_byte == CH_BSLASH) begin
          mode_next = M_ESC;
        end else begin
          grp.bytes[0] = in_data.in_byte;
          grp.cnt      = 2'd1;
        end
      end
    endcase
    if (in_data.in_last) begin
      // A trailing backslash goes out as is; an unfinished escape is decoded
      // from the digits received so far.
      if (mode_next == M_ESC) begin
        grp.bytes[0] = CH_BSLASH;
        grp.cnt      = 2'd1;
      end else if (mode_next == M_HEX) begin
        grp = utf8_enc(code_value_next);
      end
      mode_next        = M_TEXT;
      hex_count_next   = 2'd0;
      code_value_next  = 16'h0000;
      hex_stopped_next = 1'b0;
    end
    grp.last = in_data.in_last;
  end

  assign push      = take && (grp.cnt != 2'd0 || in_data.in_last);
  assign push_data = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_TEXT;
      hex_count   <= 2'd0;
      code_value  <= 16'h0000;
      hex_stopped <= 1'b0;
    end else if (take) begin
      mode        <= mode_next;
      hex_count   <= hex_count_next;
      code_value  <= code_value_next;
      hex_stopped <= hex_stopped_next;
    end
  end

  a_count_in_hex: assert property (@(posedge clk) disable iff (rst)
    hex_count != 2'd0 |-> mode == M_HEX)
    else $error("hex digit count outside a unicode escape");

  a_stop_in_hex: assert property (@(posedge clk) disable iff (rst)
    hex_stopped |-> mode == M_HEX)
    else $error("hex stop flag outside a unicode escape");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && in_data.in_last |=> mode == M_TEXT && code_value == 16'h0000)
    else $error("escape state survived the end of a string");

endmodule

// File: hw/rtl/jeu_fifo.sv
// ----------------------------------------------------------------------------
// jeu_fifo
// Short queue of byte groups between the escape decoder and the collapser.
// ----------------------------------------------------------------------------
module jeu_fifo import jeu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  grp_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output grp_t head
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  grp_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("group queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("group queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QDEPTH))
    else $error("group queue count out of range");

endmodule

// File: hw/rtl/jeu_back.sv
// ----------------------------------------------------------------------------
// jeu_back
// Collapser: walks queued groups a byte a cycle unless stalled, folds each
// '&' and any following "amp;" into one '&', and drives the output register.
// ----------------------------------------------------------------------------
module jeu_back import jeu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  grp_t q_head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [1:0] idx, idx_next;
  logic       flushing, flushing_next;
  logic [1:0] fidx, fidx_next;
  logic       after_amp, after_amp_next;
  logic [1:0] amp_len, amp_len_next;
  logic       pend_valid, pend_valid_next;
  logic [7:0] pend_byte, pend_byte_next;
  logic       out_valid_next;
  out_t       out_data_next;

  logic       step;
  logic       have_byte;
  logic [7:0] cur;
  logic       mismatch;
  logic       do_flush;
  logic       produce;
  logic       finish;
  logic [7:0] pbyte;

  assign step      = q_valid && (!out_valid || out_ready);
  assign have_byte = idx < q_head.cnt;
  assign cur       = q_head.bytes[idx];
  assign mismatch  = cur != AMP_TAIL[amp_len];
  // Held bytes of a partial "amp;" go out before a byte that breaks the
  // match, and at the end of the string.
  assign do_flush  = have_byte ? (flushing || (after_amp && mismatch && amp_len != 2'd0))
                               : (amp_len != 2'd0);

  always_comb begin
    idx_next        = idx;
    flushing_next   = flushing;
    fidx_next       = fidx;
    after_amp_next  = after_amp;
    amp_len_next    = amp_len;
    pend_valid_next = pend_valid;
    pend_byte_next  = pend_byte;
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    pop             = 1'b0;
    produce         = 1'b0;
    finish          = 1'b0;
    pbyte           = cur;

    if (step) begin
      if (do_flush) begin
        produce = 1'b1;
        pbyte   = AMP_TAIL[fidx];
        if (fidx == amp_len - 2'd1) begin
          fidx_next      = 2'd0;
          flushing_next  = 1'b0;
          amp_len_next   = 2'd0;
          after_amp_next = 1'b0;
        end else begin
          fidx_next     = fidx + 2'd1;
          flushing_next = 1'b1;
        end
      end else if (have_byte) begin
        if (after_amp && !mismatch) begin
          amp_len_next = (amp_len == 2'd3) ? 2'd0 : amp_len + 2'd1;
        end else begin
          produce        = 1'b1;
          after_amp_next = (cur == CH_AMP);
        end
        if (idx + 2'd1 == q_head.cnt && !q_head.last) begin
          pop      = 1'b1;
          idx_next = 2'd0;
        end else begin
          idx_next = idx + 2'd1;
        end
      end else begin
        finish         = 1'b1;
        pop            = 1'b1;
        idx_next       = 2'd0;
        after_amp_next = 1'b0;
        amp_len_next   = 2'd0;
      end
    end

    // Within the final item of a string the newest byte is held as pending
    // until the next byte or the end, so that the last one can carry the last
    // flag. Bytes of earlier items go straight out.
    if (produce && q_head.last) begin
      pend_valid_next = 1'b1;
      pend_byte_next  = pbyte;
    end
    if (finish) begin
      pend_valid_next = 1'b0;
    end

    if (produce && !q_head.last) begin
      out_valid_next         = 1'b1;
      out_data_next.out_byte = pbyte;
      out_data_next.no_byte  = 1'b0;
      out_data_next.out_last = 1'b0;
    end else if (produce && pend_valid) begin
      out_valid_next         = 1'b1;
      out_data_next.out_byte = pend_byte;
      out_data_next.no_byte  = 1'b0;
      out_data_next.out_last = 1'b0;
    end else if (finish) begin
      out_valid_next         = 1'b1;
      out_data_next.out_byte = pend_valid ? pend_byte : 8'h00;
      out_data_next.no_byte  = !pend_valid;
      out_data_next.out_last = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= 2'd0;
      flushing   <= 1'b0;
      fidx       <= 2'd0;
      after_amp  <= 1'b0;
      amp_len    <= 2'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      idx        <= idx_next;
      flushing   <= flushing_next;
      fidx       <= fidx_next;
      after_amp  <= after_amp_next;
      amp_len    <= amp_len_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
    pend_byte <= pend_byte_next;
    out_data  <= out_data_next;
  end

  a_held_needs_amp: assert property (@(posedge clk) disable iff (rst)
    amp_len != 2'd0 |-> after_amp)
    else $error("amp tail held without a preceding ampersand");

  a_flush_in_range: assert property (@(posedge clk) disable iff (rst)
    flushing |-> amp_len != 2'd0 && fidx < amp_len)
    else $error("flush index beyond the held bytes");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    finish |=> !pend_valid && amp_len == 2'd0 && !after_amp)
    else $error("collapser state survived the end of a string");

endmodule

// File: hw/rtl/json_escape_to_utf8_decoder_core.sv
// ----------------------------------------------------------------------------
// json_escape_to_utf8_decoder_core
// JSON string unescape to UTF-8 with "&amp;" collapsing.
// ----------------------------------------------------------------------------
// The block takes one byte of an escaped string per cycle, as long as its
// four-entry group queue has room, and gives at most one result per cycle
// while out_ready allows. An input byte turns into zero to three bytes in
// the escape decoder; the collapser handles those bytes one at a time, as
// it does each held "amp;" byte sent out when a match breaks or a string
// ends, plus one more step at the end of every string for the final result.
// Plain text therefore runs at one byte a cycle while out_ready allows, and
// the queue absorbs the longer UTF-8 expansions. A result passes through the
// group queue and the output register. The last byte of a string also waits
// in the pending register, since within that item the collapser holds each
// byte back until it knows which one ends the string.
module json_escape_to_utf8_decoder_core import jeu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic push;
  grp_t push_data;
  logic q_full;
  logic pop;
  logic q_valid;
  grp_t q_head;

  jeu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  jeu_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  jeu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
